// File: src/pct_pkg.sv
// Shared types and constants for the propagation cycle tracker.
// Used by pct_cmp, the top level and the checker; no dependencies.
package pct_pkg;

  localparam int TIME_W = 48;
  localparam int ADDR_W = 16;
  localparam int SEQ_W  = 16;
  localparam int ROLE_W = 2;
  localparam int OUTC_W = 3;
  localparam int SLOT_W = 3;
  localparam int CNT_W  = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic FUNC_TRACK = 1'b0;
  localparam logic FUNC_COUNT = 1'b1;

  localparam logic [OUTC_W-1:0] OUTC_NEW        = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_UPDATED    = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_FULL       = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_NOT_FUTURE = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_COUNT      = 3'd4;

  localparam logic [ROLE_W-1:0] ROLE_FREE = 2'd0;

  typedef struct packed {
    logic [ADDR_W-1:0] origin;
    logic [SEQ_W-1:0]  sequence_num;
    logic [ROLE_W-1:0] role;
    logic [TIME_W-1:0] end_ms;
  } entry_t;

  // Result of the shared time comparator: a < b and a > b.
  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_MERGE,
    ST_RESP
  } state_t;

endpackage

// File: src/pct_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the cycle table entries.
module pct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/pct_cmp.sv
// Shared 48-bit time comparator used for expiry, liveness and end-time checks.
// Depends on pct_pkg.
module pct_cmp (
  input  logic [pct_pkg::TIME_W-1:0] a,
  input  logic [pct_pkg::TIME_W-1:0] b,
  output pct_pkg::cmp_res_t          res
);
  import pct_pkg::*;

  always_comb begin
    res.lt = (a < b);
    res.gt = (a > b);
  end

endmodule

// File: src/propagation_cycle_tracker.sv
// Propagation cycle tracker: table of message cycles scanned one entry per cycle.
// Each word reads every table entry once from the table RAM and uses the comparator once
// per entry. A count word then goes to the response state; any other word goes through the
// check state, and a merge also through the merge state. A new word is accepted only after
// the previous result has been handed to the output register, which waits while an earlier
// result word is still held. Reset (rst_n low, synchronous) clears all live flags at once,
// so every entry is free; the table RAM itself needs no clearing pass.
module propagation_cycle_tracker #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [pct_pkg::TIME_W-1:0]  in_now_ms,
  input  logic [pct_pkg::TIME_W-1:0]  in_end_time,
  input  logic [pct_pkg::ADDR_W-1:0]  in_origin,
  input  logic [pct_pkg::SEQ_W-1:0]   in_sequence_req,
  input  logic [pct_pkg::ROLE_W-1:0]  in_role,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pct_pkg::OUTC_W-1:0]  out_outcome,
  output logic [pct_pkg::SLOT_W-1:0]  out_slot,
  output logic [pct_pkg::CNT_W-1:0]   out_active_count
);
  import pct_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Control state.
  state_t                   state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] live_r, live_nxt;
  logic                     rd_done_r, rd_done_nxt;
  logic                     pend_r, pend_nxt;
  logic                     match_vld_r, match_vld_nxt;
  logic                     free_vld_r, free_vld_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // Working registers of the current word.
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic [IDX_W-1:0]  found_idx_r, found_idx_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [ROLE_W-1:0] stored_role_r, stored_role_nxt;
  logic [TIME_W-1:0] stored_end_r, stored_end_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              req_func_r;
  logic [TIME_W-1:0] req_now_r;
  logic [TIME_W-1:0] req_end_r;
  logic [ADDR_W-1:0] req_origin_r;
  logic [SEQ_W-1:0]  req_seq_r;
  logic [ROLE_W-1:0] req_role_r;
  logic [OUTC_W-1:0] res_outcome_r, res_outcome_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic [OUTC_W-1:0] out_outcome_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [CNT_W-1:0]  out_cnt_r;

  // Table RAM ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  entry_t           ram_rdata;

  // Shared comparator.
  logic [TIME_W-1:0] cmp_a;
  logic [TIME_W-1:0] cmp_b;
  cmp_res_t          cmp_res;

  logic              accept;
  logic              live_cur;
  logic              live_after;
  logic              key_hit;
  logic [IDX_W+2:0]  found_slot_ext;
  logic [IDX_W+2:0]  free_slot_ext;

  pct_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  pct_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // The slot output carries the low three bits of the entry index.
  assign found_slot_ext = {3'b000, found_idx_r};
  assign free_slot_ext  = {3'b000, free_idx_r};

  // The entry being examined this cycle, as read from the table in the previous cycle.
  // An expired entry is no longer live and cannot match, but it is free.
  assign live_cur   = live_r[pend_idx_r];
  assign live_after = live_cur && !cmp_res.lt;
  assign key_hit    = (ram_rdata.origin == req_origin_r) &&
                      (ram_rdata.sequence_num == req_seq_r);

  // The comparator serves the scan (stored end against now), the future check
  // (requested end against now) and the merge (requested end against stored end).
  always_comb begin
    case (state_r)
      ST_CHECK: begin
        cmp_a = req_end_r;
        cmp_b = req_now_r;
      end
      ST_MERGE: begin
        cmp_a = req_end_r;
        cmp_b = stored_end_r;
      end
      default: begin
        cmp_a = ram_rdata.end_ms;
        cmp_b = req_now_r;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    live_nxt        = live_r;
    rd_done_nxt     = rd_done_r;
    pend_nxt        = 1'b0;
    match_vld_nxt   = match_vld_r;
    free_vld_nxt    = free_vld_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    rd_idx_nxt      = rd_idx_r;
    pend_idx_nxt    = pend_idx_r;
    found_idx_nxt   = found_idx_r;
    free_idx_nxt    = free_idx_r;
    stored_role_nxt = stored_role_r;
    stored_end_nxt  = stored_end_r;
    cnt_nxt         = cnt_r;
    res_outcome_nxt = res_outcome_r;
    res_slot_nxt    = res_slot_r;
    res_cnt_nxt     = res_cnt_r;
    ram_we          = 1'b0;
    ram_waddr       = free_idx_r;
    ram_wdata       = '{origin: req_origin_r, sequence_num: req_seq_r,
                        role: req_role_r, end_ms: req_end_r};
    ram_re          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt     = ST_SCAN;
          rd_idx_nxt    = '0;
          rd_done_nxt   = 1'b0;
          match_vld_nxt = 1'b0;
          free_vld_nxt  = 1'b0;
          cnt_nxt       = '0;
        end
      end

      ST_SCAN: begin
        // Read side: one entry address per cycle.
        if (!rd_done_r) begin
          ram_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r;
          if (rd_idx_r == LAST_IDX) begin
            rd_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        // Evaluate side: the entry read in the previous cycle.
        if (pend_r) begin
          if (req_func_r == FUNC_COUNT) begin
            if (live_cur && cmp_res.gt && (cnt_r != CNT_MAX)) begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end else begin
            if (cmp_res.lt) begin
              live_nxt[pend_idx_r] = 1'b0;
            end
            // The highest-numbered match wins, so later hits overwrite.
            if (live_after && key_hit) begin
              match_vld_nxt   = 1'b1;
              found_idx_nxt   = pend_idx_r;
              stored_role_nxt = ram_rdata.role;
              stored_end_nxt  = ram_rdata.end_ms;
            end
            // The lowest free entry is kept.
            if (!live_after && !free_vld_r) begin
              free_vld_nxt = 1'b1;
              free_idx_nxt = pend_idx_r;
            end
          end
          if (pend_idx_r == LAST_IDX) begin
            if (req_func_r == FUNC_COUNT) begin
              state_nxt       = ST_RESP;
              res_outcome_nxt = OUTC_COUNT;
              res_slot_nxt    = '0;
              res_cnt_nxt     = cnt_nxt;
            end else begin
              state_nxt = ST_CHECK;
            end
          end
        end
      end

      ST_CHECK: begin
        res_slot_nxt = '0;
        res_cnt_nxt  = '0;
        if (!match_vld_r && !free_vld_r) begin
          res_outcome_nxt = OUTC_FULL;
          state_nxt       = ST_RESP;
        end else if (!cmp_res.gt) begin
          res_outcome_nxt = OUTC_NOT_FUTURE;
          state_nxt       = ST_RESP;
        end else if (!match_vld_r) begin
          // New entry: a role of zero leaves it free.
          ram_we               = 1'b1;
          ram_waddr            = free_idx_r;
          live_nxt[free_idx_r] = (req_role_r != ROLE_FREE);
          res_outcome_nxt      = OUTC_NEW;
          res_slot_nxt         = free_slot_ext[SLOT_W-1:0];
          state_nxt            = ST_RESP;
        end else begin
          state_nxt = ST_MERGE;
        end
      end

      ST_MERGE: begin
        // The stored role is nonzero, so the entry stays live.
        ram_we           = 1'b1;
        ram_waddr        = found_idx_r;
        ram_wdata.role   = (req_role_r > stored_role_r) ? req_role_r : stored_role_r;
        ram_wdata.end_ms = cmp_res.gt ? req_end_r : stored_end_r;
        res_outcome_nxt  = OUTC_UPDATED;
        res_slot_nxt     = found_slot_ext[SLOT_W-1:0];
        res_cnt_nxt      = '0;
        state_nxt        = ST_RESP;
      end

      ST_RESP: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_r      <= '0;
      rd_done_r   <= 1'b0;
      pend_r      <= 1'b0;
      match_vld_r <= 1'b0;
      free_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      rd_done_r   <= rd_done_nxt;
      pend_r      <= pend_nxt;
      match_vld_r <= match_vld_nxt;
      free_vld_r  <= free_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    pend_idx_r    <= pend_idx_nxt;
    found_idx_r   <= found_idx_nxt;
    free_idx_r    <= free_idx_nxt;
    stored_role_r <= stored_role_nxt;
    stored_end_r  <= stored_end_nxt;
    cnt_r         <= cnt_nxt;
    res_outcome_r <= res_outcome_nxt;
    res_slot_r    <= res_slot_nxt;
    res_cnt_r     <= res_cnt_nxt;
    if (accept) begin
      req_func_r   <= in_func;
      req_now_r    <= in_now_ms;
      req_end_r    <= in_end_time;
      req_origin_r <= in_origin;
      req_seq_r    <= in_sequence_req;
      req_role_r   <= in_role;
    end
    if ((state_r == ST_RESP) && (!out_valid_r || out_ready)) begin
      out_outcome_r <= res_outcome_r;
      out_slot_r    <= res_slot_r;
      out_cnt_r     <= res_cnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_slot         = out_slot_r;
  assign out_active_count = out_cnt_r;

endmodule

// File: src/pct_checker.sv
// Port-level checker for the propagation cycle tracker, bound to the top level.
// Depends on pct_pkg and propagation_cycle_tracker.
module pct_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pct_pkg::OUTC_W-1:0]  out_outcome,
  input logic [pct_pkg::SLOT_W-1:0]  out_slot,
  input logic [pct_pkg::CNT_W-1:0]   out_active_count
);
  import pct_pkg::*;

  // A held result word keeps its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_outcome) &&
    $stable(out_slot) && $stable(out_active_count))
    else $error("result word changed while stalled");

  // The block handles one word at a time, so it is busy right after accepting one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again in the following cycle");

  // Only a count reply carries a count.
  a_count_only_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome != OUTC_COUNT) |-> (out_active_count == '0))
    else $error("nonzero count on a track result");

  // Outcomes that use no entry report slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_outcome == OUTC_FULL) || (out_outcome == OUTC_NOT_FUTURE) ||
    (out_outcome == OUTC_COUNT)) |-> (out_slot == '0))
    else $error("slot set on a result that used no entry");

endmodule

bind propagation_cycle_tracker pct_checker u_pct_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_outcome      (out_outcome),
  .out_slot         (out_slot),
  .out_active_count (out_active_count)
);
